[design/gtg_pkg.sv]
// Shared types, register codes and the arctangent table for the go-to-goal
// heading controller. No dependencies.
package gtg_pkg;

    localparam int ATAN_ENTRIES = 20;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POS_TOL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_TOL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_SPEED = 3'd5;

    // pi in units of 2^-24 rad
    localparam logic signed [27:0] PI_Z = 28'sd52707179;

    typedef struct packed {
        logic signed [15:0] robot_x;
        logic signed [15:0] robot_y;
        logic signed [15:0] robot_heading;
    } pose_t;

    typedef struct packed {
        logic [14:0]        linear_speed;
        logic signed [15:0] angular_rate;
        logic               arrived;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic [15:0]        turn_gain;
        logic [14:0]        position_tolerance;
        logic [14:0]        angle_tolerance;
        logic [14:0]        forward_speed;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        goal_x:             16'sd1107,
        goal_y:             -16'sd983,
        turn_gain:          16'd8192,
        position_tolerance: 15'd410,
        angle_tolerance:    15'd819,
        forward_speed:      15'd819
    };

    // One item in flight through the vectoring stages
    typedef struct packed {
        logic               valid;
        logic               arrived;
        logic               at_goal;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [27:0] z;
        logic signed [15:0] heading;
    } cordic_t;

    // atan(2^-i) in units of 2^-24 rad, rounded to nearest
    function automatic logic signed [27:0] atan_entry(input logic [4:0] idx);
        logic signed [27:0] v;
        case (idx)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

endpackage

[design/gtg_front.sv]
// Entry stage: goal offset, arrival test and quadrant fold ahead of the CORDIC.
// Depends on gtg_pkg.
module gtg_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  gtg_pkg::pose_t  pose,
    input  gtg_pkg::cfg_t   cfg,
    output gtg_pkg::cordic_t out
);
    import gtg_pkg::*;

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0]        adx;
    logic [16:0]        ady;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    cordic_t            stage_next;
    cordic_t            stage_reg;

    always_comb
    begin
        dx  = {cfg.goal_x[15], cfg.goal_x} - {pose.robot_x[15], pose.robot_x};
        dy  = {cfg.goal_y[15], cfg.goal_y} - {pose.robot_y[15], pose.robot_y};
        adx = dx[16] ? 17'(-dx) : 17'(dx);
        ady = dy[16] ? 17'(-dy) : 17'(dy);
        xs  = {{3{dx[16]}}, dx, 12'd0};
        ys  = {{3{dy[16]}}, dy, 12'd0};

        stage_next.valid   = accept;
        stage_next.arrived = (adx < {2'b00, cfg.position_tolerance})
                          && (ady < {2'b00, cfg.position_tolerance});
        stage_next.at_goal = (dx == 17'sd0) && (dy == 17'sd0);
        stage_next.heading = pose.robot_heading;
        // left half-plane: rotate by pi first
        if (dx[16])
        begin
            stage_next.x = -xs;
            stage_next.y = -ys;
            stage_next.z = dy[16] ? -PI_Z : PI_Z;
        end
        else
        begin
            stage_next.x = xs;
            stage_next.y = ys;
            stage_next.z = 28'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else
            stage_reg <= stage_next;
    end

    assign out = stage_reg;

endmodule

[design/gtg_cordic_stage.sv]
// One vectoring iteration of the CORDIC arctangent, registered.
// Depends on gtg_pkg.
module gtg_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gtg_pkg::cordic_t  in,
    output gtg_pkg::cordic_t  out
);
    import gtg_pkg::*;

    localparam logic [4:0] IDX = 5'(STEP);

    logic signed [31:0] xsh;
    logic signed [31:0] ysh;
    cordic_t            stage_next;
    cordic_t            stage_reg;

    always_comb
    begin
        xsh        = in.x >>> STEP;
        ysh        = in.y >>> STEP;
        stage_next = in;
        if (in.y > 32'sd0)
        begin
            stage_next.x = in.x + ysh;
            stage_next.y = in.y - xsh;
            stage_next.z = in.z + atan_entry(IDX);
        end
        else
        begin
            stage_next.x = in.x - ysh;
            stage_next.y = in.y + xsh;
            stage_next.z = in.z - atan_entry(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else
            stage_reg <= stage_next;
    end

    assign out = stage_reg;

endmodule

[design/gtg_back.sv]
// Back end: bearing rounding, heading error, gain multiply, saturation and
// command select over three register stages. Depends on gtg_pkg.
module gtg_back (
    input  logic              clk,
    input  logic              rst_n,
    input  gtg_pkg::cordic_t  in,
    input  gtg_pkg::cfg_t     cfg,
    output logic              done,
    output gtg_pkg::cmd_t     cmd
);
    import gtg_pkg::*;

    // stage A: heading error
    logic signed [27:0] z_rnd;
    logic signed [16:0] bearing;
    logic signed [17:0] err_next;
    logic signed [17:0] err_reg;
    logic               a_valid_reg;
    logic               a_arrived_reg;

    // stage B: multiply and threshold
    logic [17:0]        abs_err;
    logic signed [34:0] prod_next;
    logic signed [34:0] prod_reg;
    logic               turn_next;
    logic               turn_reg;
    logic               b_valid_reg;
    logic               b_arrived_reg;

    // stage C: round, saturate, select
    logic signed [35:0] prod_rnd;
    logic signed [21:0] rate_wide;
    logic signed [15:0] rate_sat;
    cmd_t               cmd_next;
    cmd_t               cmd_reg;
    logic               done_reg;

    always_comb
    begin
        z_rnd    = in.z + 28'sd1024;
        bearing  = in.at_goal ? 17'sd0 : z_rnd[27:11];
        err_next = {bearing[16], bearing} - {{2{in.heading[15]}}, in.heading};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            a_arrived_reg <= 1'b0;
            err_reg       <= '0;
        end
        else
        begin
            a_valid_reg   <= in.valid;
            a_arrived_reg <= in.arrived;
            err_reg       <= err_next;
        end
    end

    always_comb
    begin
        abs_err   = err_reg[17] ? 18'(-err_reg) : 18'(err_reg);
        turn_next = abs_err > {3'b000, cfg.angle_tolerance};
        prod_next = $signed({1'b0, cfg.turn_gain}) * err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            b_arrived_reg <= 1'b0;
            turn_reg      <= 1'b0;
            prod_reg      <= '0;
        end
        else
        begin
            b_valid_reg   <= a_valid_reg;
            b_arrived_reg <= a_arrived_reg;
            turn_reg      <= turn_next;
            prod_reg      <= prod_next;
        end
    end

    always_comb
    begin
        prod_rnd  = {prod_reg[34], prod_reg} + 36'sd8192;
        rate_wide = prod_rnd[35:14];
        if (rate_wide > 22'sd32767)
            rate_sat = 16'sh7FFF;
        else if (rate_wide < -22'sd32768)
            rate_sat = -16'sd32768;
        else
            rate_sat = rate_wide[15:0];

        cmd_next = '0;
        if (b_arrived_reg)
            cmd_next.arrived = 1'b1;
        else if (turn_reg)
            cmd_next.angular_rate = rate_sat;
        else
            cmd_next.linear_speed = cfg.forward_speed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            cmd_reg  <= '0;
        end
        else
        begin
            done_reg <= b_valid_reg;
            cmd_reg  <= cmd_next;
        end
    end

    assign done = done_reg;
    assign cmd  = cmd_reg;

endmodule

[design/go_to_goal_heading_controller.sv]
// Go-to-goal proportional heading controller, top level.
// Depends on gtg_pkg, gtg_front, gtg_cordic_stage and gtg_back.
//
// Usage:
//   A pose item (robot_x, robot_y, robot_heading) is taken on any rising edge
//   with start high; busy is held low, so one item may enter every cycle.
//   Each item yields one drive command on cmd, marked by done for a single
//   cycle, after it has passed one entry stage, one stage per CORDIC
//   iteration, then error, multiply and saturate stages. Throughput is
//   one item per cycle; the result stream cannot be held off, so nothing
//   ever backs up.
//   Registers are written through cfg_we / cfg_index / cfg_data and are
//   only to be changed while no item is in flight; unknown indices are
//   ignored.
//   Reset (rst_n low) empties the pipeline and restores the register
//   defaults; items in flight are dropped.
module go_to_goal_heading_controller #(
    parameter int CORDIC_STEPS = 14
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  gtg_pkg::pose_t                 pose,
    output logic                           done,
    output gtg_pkg::cmd_t                  cmd,
    input  logic                           cfg_we,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gtg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gtg_pkg::*;

    localparam int LATENCY = CORDIC_STEPS + 4;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    accept;
    cordic_t chain [0:CORDIC_STEPS];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GOAL_X:    cfg_next.goal_x             = cfg_data;
                REG_GOAL_Y:    cfg_next.goal_y             = cfg_data;
                REG_TURN_GAIN: cfg_next.turn_gain          = cfg_data;
                REG_POS_TOL:   cfg_next.position_tolerance = cfg_data[14:0];
                REG_ANG_TOL:   cfg_next.angle_tolerance    = cfg_data[14:0];
                REG_FWD_SPEED: cfg_next.forward_speed      = cfg_data[14:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    gtg_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pose   (pose),
        .cfg    (cfg_reg),
        .out    (chain[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        gtg_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .in    (chain[i]),
            .out   (chain[i+1])
        );
    end

    gtg_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (chain[CORDIC_STEPS]),
        .cfg   (cfg_reg),
        .done  (done),
        .cmd   (cmd)
    );

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LATENCY) done)
        else $error("command missing at fixed latency");

    a_one_motion: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cmd.linear_speed == 15'd0 || cmd.angular_rate == 16'sd0))
        else $error("drive and turn commanded together");

    a_arrived_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cmd.arrived) |-> (cmd.linear_speed == 15'd0
                                   && cmd.angular_rate == 16'sd0))
        else $error("motion commanded after arrival");
`endif

endmodule
